@@ src/tsbg_pkg.sv @@
// ============================================================================
// Tone sweep burst generator package
// Shared types and constants for the tone sweep and burst buzzer driver.
// ============================================================================
package tsbg_pkg;

    // Item kind codes carried in the input tuser field
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_SWEEP = 2'd1;
    localparam logic [1:0] KIND_BURST = 2'd2;

    // Reset value of the gap length register, in ticks
    localparam logic [15:0] GAP_RESET = 16'd30;

    // Tone phase of the running command
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2,
        PH_GAP  = 2'd3
    } t_phase;

    // One input word, unpacked
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] period_start;
        logic [15:0] period_end;
        logic [15:0] cycle_count;
        logic [7:0]  repeat_count;
    } t_item;

    // One result word, unpacked
    typedef struct packed {
        logic rejected;
        logic done_res;
        logic busy_res;
        logic pin_level;
    } t_res;

endpackage

@@ src/tsbg_core.sv @@
// ============================================================================
// Tone sweep burst generator core
// Holds the tone state and computes the next state and the result for one
// word in a single pass of combinational logic.
// ============================================================================
module tsbg_core
    import tsbg_pkg::*;
#(
    parameter int PERIOD_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_item       i_item,
    input  logic [15:0] i_gap,
    output t_res        o_res
);

    // Counter must reach both the largest half-period and the largest gap
    localparam int CW = (PERIOD_WIDTH > 16) ? PERIOD_WIDTH : 16;

    t_phase                  r_phase, n_phase;
    logic                    r_burst, n_burst;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [PERIOD_WIDTH-1:0] r_cur, n_cur;
    logic [PERIOD_WIDTH-1:0] r_tgt, n_tgt;
    logic [15:0]             r_cl, n_cl;
    logic [15:0]             r_cpr, n_cpr;
    logic [7:0]              r_reps, n_reps;

    logic                    done;
    logic                    rej;
    logic                    do_begin;
    logic [7:0]              rep_val;
    logic [15:0]             cpr_val;
    logic [15:0]             cl_dec;
    logic [CW-1:0]           cnt_inc;
    logic [PERIOD_WIDTH-1:0] hp;
    logic [PERIOD_WIDTH-1:0] cur_step;
    logic [PERIOD_WIDTH-1:0] in_start;
    logic [PERIOD_WIDTH-1:0] in_end;

    assign in_start = PERIOD_WIDTH'(i_item.period_start);
    assign in_end   = PERIOD_WIDTH'(i_item.period_end);

    // Next state and result for the current word
    always_comb begin
        n_phase  = r_phase;
        n_burst  = r_burst;
        n_cnt    = r_cnt;
        n_cur    = r_cur;
        n_tgt    = r_tgt;
        n_cl     = r_cl;
        n_cpr    = r_cpr;
        n_reps   = r_reps;
        done     = 1'b0;
        rej      = 1'b0;
        do_begin = 1'b0;
        rep_val  = r_reps;
        cpr_val  = r_cpr;
        cl_dec   = r_cl - 16'd1;
        cnt_inc  = r_cnt + CW'(1);
        hp       = (r_cur == '0) ? PERIOD_WIDTH'(1) : r_cur;

        // Sweep steps the period by one toward the end value
        if (r_cur > r_tgt) begin
            cur_step = r_cur - PERIOD_WIDTH'(1);
        end else if (r_cur < r_tgt) begin
            cur_step = r_cur + PERIOD_WIDTH'(1);
        end else begin
            cur_step = r_cur;
        end

        case (i_item.kind)
            KIND_TICK: begin
                case (r_phase)
                    PH_LOW: begin
                        n_cnt = cnt_inc;
                        if (cnt_inc >= CW'(hp)) begin
                            n_cnt   = '0;
                            n_phase = PH_HIGH;
                        end
                    end
                    PH_HIGH: begin
                        n_cnt = cnt_inc;
                        if (cnt_inc >= CW'(hp)) begin
                            n_cnt = '0;
                            if (r_burst) begin
                                n_cl = cl_dec;
                                if (cl_dec != '0) begin
                                    n_phase = PH_LOW;
                                end else if (i_gap != '0) begin
                                    n_phase = PH_GAP;
                                end else begin
                                    do_begin = 1'b1;
                                    rep_val  = r_reps - 8'd1;
                                end
                            end else begin
                                n_cur = cur_step;
                                if (cur_step == r_tgt) begin
                                    n_phase = PH_IDLE;
                                    done    = 1'b1;
                                end else begin
                                    n_phase = PH_LOW;
                                end
                            end
                        end
                    end
                    PH_GAP: begin
                        n_cnt = cnt_inc;
                        if (cnt_inc >= CW'(i_gap)) begin
                            n_cnt    = '0;
                            do_begin = 1'b1;
                            rep_val  = r_reps - 8'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            KIND_SWEEP, KIND_BURST: begin
                if (r_phase != PH_IDLE) begin
                    rej = 1'b1;
                end else if (i_item.kind == KIND_SWEEP) begin
                    n_burst = 1'b0;
                    n_cur   = in_start;
                    n_tgt   = in_end;
                    n_cnt   = '0;
                    if (in_start == in_end) begin
                        done = 1'b1;
                    end else begin
                        n_phase = PH_LOW;
                    end
                end else begin
                    n_burst  = 1'b1;
                    n_cur    = in_start;
                    n_cpr    = i_item.cycle_count;
                    do_begin = 1'b1;
                    rep_val  = i_item.repeat_count;
                    cpr_val  = i_item.cycle_count;
                end
            end
            default: begin
            end
        endcase

        // Start of a burst repeat, or end of the burst
        if (do_begin) begin
            n_reps = rep_val;
            n_cnt  = '0;
            if (rep_val == '0) begin
                n_phase = PH_IDLE;
                done    = 1'b1;
            end else if (cpr_val != '0) begin
                n_cl    = cpr_val;
                n_phase = PH_LOW;
            end else if (i_gap != '0) begin
                n_phase = PH_GAP;
            end else begin
                n_phase = PH_IDLE;
                done    = 1'b1;
            end
        end

        o_res.pin_level = (n_phase == PH_HIGH);
        o_res.busy_res  = (n_phase != PH_IDLE);
        o_res.done_res  = done;
        o_res.rejected  = rej;
    end

    // Tone state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_burst <= 1'b0;
            r_cnt   <= '0;
            r_cur   <= '0;
            r_tgt   <= '0;
            r_cl    <= '0;
            r_cpr   <= '0;
            r_reps  <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_burst <= n_burst;
            r_cnt   <= n_cnt;
            r_cur   <= n_cur;
            r_tgt   <= n_tgt;
            r_cl    <= n_cl;
            r_cpr   <= n_cpr;
            r_reps  <= n_reps;
        end
    end

endmodule

@@ src/tone_sweep_burst_generator_top.sv @@
// ============================================================================
// Tone sweep burst generator top level
// Buzzer pin driver stepped by tick and command words on a stream input.
// ============================================================================
// Every input word yields exactly one result word. The block takes one word
// per clock cycle when the output side keeps up. An accepted word waits in
// the input register, and the tone state is updated as it moves into the
// result register, from which it is offered on the output. Tick words
// advance the tone; sweep and burst words start a command when idle and are
// flagged as rejected while one runs. The gap length register is written on
// the configuration channel, which is always ready, and should be changed
// only while no word is in flight.
module tone_sweep_burst_generator_top
    import tsbg_pkg::*;
#(
    parameter int PERIOD_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,  // period_start, period_end, cycle_count, repeat_count
    input  logic [1:0]  i_s_tuser,  // kind
    // Output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // pin_level, busy_res, done_res, rejected, zero pad
    // Configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data  // gap_ticks
);

    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_res        r_out;
    logic [15:0] r_gap;
    logic        out_free;
    logic        step_en;
    t_res        step_res;

    // Pipeline flow control
    assign out_free    = !r_out_valid || i_m_tready;
    assign o_s_tready  = !r_in_valid || out_free;
    assign step_en     = r_in_valid && out_free;
    assign o_cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.kind         <= i_s_tuser;
            r_in.period_start <= i_s_tdata[15:0];
            r_in.period_end   <= i_s_tdata[31:16];
            r_in.cycle_count  <= i_s_tdata[47:32];
            r_in.repeat_count <= i_s_tdata[55:48];
        end
    end

    // Gap length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= GAP_RESET;
        end else if (i_cfg_valid) begin
            r_gap <= i_cfg_data;
        end
    end

    // Tone state and step logic
    tsbg_core #(
        .PERIOD_WIDTH(PERIOD_WIDTH)
    ) u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (step_en),
        .i_item (r_in),
        .i_gap  (r_gap),
        .o_res  (step_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_out <= step_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out.rejected, r_out.done_res,
                         r_out.busy_res, r_out.pin_level};

endmodule

@@ src/tsbg_chk.sv @@
// ============================================================================
// Tone sweep burst generator checker
// Port-level checks on reset, output stalls and the consistency of results.
// ============================================================================
module tsbg_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);

    // No result word is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result word offered after reset");

    // A stalled result word holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result word changed");

    // The pin is only high while a command runs.
    a_pin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> o_m_tdata[1])
        else $error("pin high while idle");

    // A finishing word leaves the block idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2] |-> !o_m_tdata[1] && !o_m_tdata[3])
        else $error("done word shows busy or rejected");

    // A rejected command only happens while busy.
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[3] |-> o_m_tdata[1])
        else $error("command rejected while idle");

endmodule

bind tone_sweep_burst_generator_top tsbg_chk u_tsbg_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata)
);

@@ sim/tone_sweep_burst_generator_top_tb.sv @@
// ============================================================================
// Tone sweep burst generator testbench
// Drives tick, sweep and burst words into the block with random idling on
// both streams, predicts every result word from a local model of the tone
// state and gap register, and compares each field of each returned word.
// ============================================================================
module tone_sweep_burst_generator_top_tb;
    import tsbg_pkg::*;

    // The one kind code that the block ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_PRINTED = 30;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        o_s_tready;
    logic [55:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        o_m_tvalid;
    logic        m_tready;
    logic [7:0]  o_m_tdata;
    logic        cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] cfg_data;

    // Predicted tone state and gap register
    t_phase      ph;
    logic        burst_mode;
    int unsigned half_cnt;
    logic [15:0] cur_per;
    logic [15:0] tgt_per;
    logic [15:0] cyc_left;
    logic [15:0] cyc_per_rep;
    logic [7:0]  rep_left;
    logic [15:0] gap_len;

    // Expected result words, oldest first
    t_res        expected_levels[$];
    t_res        seen_res;
    t_res        due_res;
    int unsigned mismatch_count;

    // Idling controls for both streams
    bit          tx_idle_en;
    bit          rx_idle_en;
    int unsigned rx_pause;
    int unsigned rx_hold;

    tone_sweep_burst_generator_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Starts the next burst repeat, after counting one down if asked.
    // Returns 1 when the burst has ended.
    function automatic bit next_repeat(input bit count_down);
        if (count_down) rep_left = rep_left - 8'd1;
        half_cnt = 0;
        if (rep_left == 8'd0) begin
            ph = PH_IDLE;
            return 1'b1;
        end
        if (cyc_per_rep != 16'd0) begin
            cyc_left = cyc_per_rep;
            ph = PH_LOW;
            return 1'b0;
        end
        if (gap_len != 16'd0) begin
            ph = PH_GAP;
            return 1'b0;
        end
        ph = PH_IDLE;
        return 1'b1;
    endfunction

    // Advances the tone state by one accepted word and returns its result.
    function automatic t_res tone_predict(input t_item it);
        logic [15:0] half_len;
        bit          done;
        bit          rej;
        t_res        res;
        done = 1'b0;
        rej = 1'b0;
        half_len = (cur_per == 16'd0) ? 16'd1 : cur_per;
        case (it.kind)
            KIND_TICK: begin
                case (ph)
                    PH_LOW: begin
                        half_cnt++;
                        if (half_cnt >= half_len) begin
                            half_cnt = 0;
                            ph = PH_HIGH;
                        end
                    end
                    PH_HIGH: begin
                        half_cnt++;
                        if (half_cnt >= half_len) begin
                            half_cnt = 0;
                            if (burst_mode) begin
                                cyc_left = cyc_left - 16'd1;
                                if (cyc_left != 16'd0) ph = PH_LOW;
                                else if (gap_len != 16'd0) ph = PH_GAP;
                                else done = next_repeat(1'b1);
                            end else begin
                                // A sweep steps one toward its end after each cycle.
                                if (cur_per > tgt_per) cur_per = cur_per - 16'd1;
                                else if (cur_per < tgt_per) cur_per = cur_per + 16'd1;
                                if (cur_per == tgt_per) begin
                                    ph = PH_IDLE;
                                    done = 1'b1;
                                end else begin
                                    ph = PH_LOW;
                                end
                            end
                        end
                    end
                    PH_GAP: begin
                        half_cnt++;
                        if (half_cnt >= gap_len) done = next_repeat(1'b1);
                    end
                    default: ;
                endcase
            end
            KIND_SWEEP, KIND_BURST: begin
                if (ph != PH_IDLE) begin
                    rej = 1'b1;
                end else if (it.kind == KIND_SWEEP) begin
                    burst_mode = 1'b0;
                    cur_per = it.period_start;
                    tgt_per = it.period_end;
                    half_cnt = 0;
                    if (it.period_start == it.period_end) done = 1'b1;
                    else ph = PH_LOW;
                end else begin
                    burst_mode = 1'b1;
                    cur_per = it.period_start;
                    cyc_per_rep = it.cycle_count;
                    rep_left = it.repeat_count;
                    done = next_repeat(1'b0);
                end
            end
            default: ;
        endcase
        res.pin_level = (ph == PH_HIGH);
        res.busy_res = (ph != PH_IDLE);
        res.done_res = done;
        res.rejected = rej;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic got, input logic want);
        if (got !== want)
            report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
    endtask

    // Each accepted result word is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && m_tready) begin
            seen_res = t_res'(o_m_tdata[3:0]);
            if (expected_levels.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                due_res = expected_levels.pop_front();
                check_field("pin_level", seen_res.pin_level, due_res.pin_level);
                check_field("busy_res", seen_res.busy_res, due_res.busy_res);
                check_field("done_res", seen_res.done_res, due_res.done_res);
                check_field("rejected", seen_res.rejected, due_res.rejected);
            end
            rx_pause = rx_idle_en ? $urandom_range(0, 19) : 0;
        end
    end

    // Output ready: a long hold-off wins over the per-word pause.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold != 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end else if (rx_pause != 0) begin
                m_tready = 1'b0;
                rx_pause--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // A word of the given kind with random content in every field.
    function automatic t_item noise_word(input logic [1:0] kind);
        t_item it;
        it.kind = kind;
        it.period_start = 16'($urandom_range(0, 65535));
        it.period_end = 16'($urandom_range(0, 65535));
        it.cycle_count = 16'($urandom_range(0, 65535));
        it.repeat_count = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Sends one word after a random pause and records its expected result.
    task automatic send_word(input t_item it);
        int unsigned pause;
        pause = tx_idle_en ? $urandom_range(0, 19) : 0;
        @(negedge i_clk);
        if (pause != 0) begin
            s_tvalid = 1'b0;
            repeat (pause) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {it.repeat_count, it.cycle_count, it.period_end, it.period_start};
        s_tuser = it.kind;
        do @(posedge i_clk); while (!o_s_tready);
        expected_levels.push_back(tone_predict(it));
    endtask

    task automatic send_tick;
        send_word(noise_word(KIND_TICK));
    endtask

    task automatic send_sweep(input logic [15:0] p_start, input logic [15:0] p_end);
        t_item it;
        it = noise_word(KIND_SWEEP);
        it.period_start = p_start;
        it.period_end = p_end;
        send_word(it);
    endtask

    task automatic send_burst(input logic [15:0] period, input logic [15:0] cycles,
                              input logic [7:0] repeats);
        t_item it;
        it = noise_word(KIND_BURST);
        it.period_start = period;
        it.cycle_count = cycles;
        it.repeat_count = repeats;
        send_word(it);
    endtask

    // Ticks until the running command has ended.
    task automatic play_out;
        while (ph != PH_IDLE) send_tick();
    endtask

    // Stops sending and waits until every expected word has come back.
    task automatic drain_all;
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (expected_levels.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [15:0] value);
        drain_all();
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        gap_len = value;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Sends a command that the block must reject, or an unused kind.
    task automatic send_noise;
        case ($urandom_range(0, 2))
            0: send_word(noise_word(KIND_SWEEP));
            1: send_word(noise_word(KIND_BURST));
            default: send_word(noise_word(KIND_UNUSED));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Ticks and unused kinds while idle, and sweeps that end at once.
    task automatic test_idle_words;
        send_tick();
        send_tick();
        send_word(noise_word(KIND_UNUSED));
        send_sweep(16'd0, 16'd0);
        send_sweep(16'hFFFF, 16'hFFFF);
        send_tick();
    endtask

    // Sweeps up, down and through a zero period, with commands refused midway.
    task automatic test_sweeps;
        send_sweep(16'd0, 16'd2);
        send_tick();
        send_word(noise_word(KIND_SWEEP));
        send_word(noise_word(KIND_BURST));
        send_word(noise_word(KIND_UNUSED));
        play_out();
        send_sweep(16'd3, 16'd1);
        send_tick();
        send_tick();
        send_word(noise_word(KIND_SWEEP));
        play_out();
        send_sweep(16'd1, 16'd0);
        play_out();
        drain_all();
    endtask

    // Bursts: zero repeats, gap-only repeats, zero-length repeats, zero gap.
    task automatic test_bursts;
        send_burst(16'hFFFF, 16'hFFFF, 8'd0);
        send_burst(16'd2, 16'd2, 8'd2);
        send_tick();
        send_word(noise_word(KIND_BURST));
        play_out();
        send_burst(16'd4, 16'd0, 8'd3);
        play_out();
        cfg_write(16'd0);
        send_burst(16'd5, 16'd0, 8'hFF);
        send_burst(16'd1, 16'd2, 8'd2);
        play_out();
        send_burst(16'd0, 16'd1, 8'd1);
        play_out();
        drain_all();
    endtask

    // The widest gap, cut short mid-gap, then a gap stretched mid-gap.
    task automatic test_gap_register;
        cfg_write(16'hFFFF);
        send_burst(16'd1, 16'd1, 8'd2);
        while (ph != PH_GAP) send_tick();
        repeat (3) send_tick();
        cfg_write(16'd2);
        send_tick();
        while (ph != PH_GAP) send_tick();
        send_tick();
        cfg_write(16'd6);
        play_out();
        cfg_write(16'd3);
    endtask

    // The output stalls for a long stretch while words keep coming, then
    // the sender waits for every result before going on.
    task automatic test_backpressure;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_burst(16'd1, 16'd3, 8'd2);
        rx_hold = 150;
        play_out();
        send_sweep(16'd2, 16'd5);
        play_out();
        drain_all();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // Mostly complete commands with random small sizes, ticked to the end,
    // with refused commands and unused kinds mixed in as noise.
    task automatic test_random_traffic;
        int unsigned counted;
        logic [15:0] p_start;
        logic [15:0] p_end;
        counted = 0;
        while (counted < 450) begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
                cfg_write(16'($urandom_range(0, 8)));
            if ($urandom_range(0, 5) == 0) send_tick();
            if ($urandom_range(0, 1) == 0) begin
                if ($urandom_range(0, 7) == 0) begin
                    p_start = 16'($urandom_range(10, 40));
                    p_end = p_start + 16'($urandom_range(0, 4)) - 16'd2;
                end else begin
                    p_start = 16'($urandom_range(0, 5));
                    p_end = 16'($urandom_range(0, 5));
                end
                send_sweep(p_start, p_end);
            end else begin
                send_burst(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                           8'($urandom_range(0, 4)));
            end
            counted++;
            while (ph != PH_IDLE) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_noise();
                end else begin
                    send_tick();
                    counted++;
                end
            end
        end
        drain_all();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_TICK;
        cfg_valid = 1'b0;
        cfg_data = '0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        rx_pause = 0;
        rx_hold = 0;
        mismatch_count = 0;
        ph = PH_IDLE;
        burst_mode = 1'b0;
        half_cnt = 0;
        cur_per = '0;
        tgt_per = '0;
        cyc_left = '0;
        cyc_per_rep = '0;
        rep_left = '0;
        gap_len = GAP_RESET;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_words();
        test_sweeps();
        test_bursts();
        test_gap_register();
        test_backpressure();
        test_random_traffic();

        drain_all();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ tone_sweep_burst_generator_top.f @@
src/tsbg_pkg.sv
src/tsbg_core.sv
src/tone_sweep_burst_generator_top.sv
src/tsbg_chk.sv
sim/tone_sweep_burst_generator_top_tb.sv
